>>> hw/rtl/wste_pkg.sv
// Shared constants and controller/datapath handshake types for the short-time energy core.
`default_nettype none

package wste_pkg;

    localparam int DEF_MAX_HALF_WINDOW = 31;
    localparam int DEF_SAMPLE_BITS     = 16;

    localparam int WIN_W    = 5;   // half window register width
    localparam int ENERGY_W = 31;  // result width

    localparam logic [WIN_W-1:0] HALF_WINDOW_RESET = 5'd8;

    // controller -> datapath
    typedef struct packed {
        logic accept;       // input transfer this cycle
        logic update;       // fold the new square into the window sum
        logic div_step;     // one restoring-division step
        logic load_result;  // load the position result into the output register
        logic load_run;     // load one trailing zero into the output register
    } wste_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic emit;         // position has a result (valid during update)
        logic need_div;     // window is full, quotient needed (valid during update)
        logic last;         // item being worked on closes the array
        logic run_pending;  // trailing zeros still owed
        logic run_final;    // exactly one trailing zero left
        logic div_done;     // final division step in progress
        logic out_free;     // output register can take a value this cycle
    } wste_status_t;

endpackage

`default_nettype wire

>>> hw/rtl/wste_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wste_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

>>> hw/rtl/wste_ctrl.sv
// Sequencing state machine for the short-time energy core.
`default_nettype none

module wste_ctrl
    import wste_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_valid,
    output logic              s_ready,
    input  wire wste_status_t st,
    output wste_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DIVIDE,
        ST_EMIT,
        ST_RUN
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
                if (s_valid) begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                cmd.update = 1'b1;
                if (st.emit) begin
                    state_next = st.need_div ? ST_DIVIDE : ST_EMIT;
                end else if (st.last) begin
                    state_next = ST_RUN;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIVIDE: begin
                cmd.div_step = 1'b1;
                if (st.div_done) begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (st.out_free) begin
                    cmd.load_result = 1'b1;
                    state_next = (st.last && st.run_pending) ? ST_RUN : ST_IDLE;
                end
            end
            ST_RUN: begin
                if (st.out_free) begin
                    cmd.load_run = 1'b1;
                    if (st.run_final) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

>>> hw/rtl/wste_datapath.sv
// Squaring, window sum, square history, serial divider and output register.
`default_nettype none

module wste_datapath
    import wste_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   cfg_wr_en,
    input  wire logic [WIN_W-1:0]       cfg_wr_data,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                   s_last,
    input  wire wste_cmd_t              cmd,
    output wste_status_t                st,
    input  wire logic                   m_ready,
    output logic                        m_valid,
    output logic [ENERGY_W-1:0]         m_energy,
    output logic                        m_last_result
);

    localparam int CNT_W   = $clog2(2 * MAX_HALF_WINDOW + 1);
    localparam int SQ_W    = 2 * SAMPLE_BITS - 1;
    localparam int SUM_W   = CNT_W + 2 * SAMPLE_BITS - 2;
    localparam int DCNT_W  = $clog2(SUM_W);
    localparam int QX_W    = (SUM_W > ENERGY_W) ? SUM_W : ENERGY_W;
    localparam int RAM_D   = 1 << CNT_W;

    logic [WIN_W-1:0]         hw_reg;
    logic [SQ_W-1:0]          sq_reg;
    logic                     last_reg;
    logic [CNT_W-1:0]         wp_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         samples_reg;
    logic [SUM_W-1:0]         qr_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic [DCNT_W-1:0]        div_cnt_reg;
    logic                     use_quot_reg;
    logic [CNT_W-1:0]         run_cnt_reg;
    logic                     m_valid_reg;
    logic [ENERGY_W-1:0]      m_energy_reg;
    logic                     m_last_reg;

    logic [CNT_W-1:0]         win;
    logic [CNT_W-1:0]         span;
    logic [CNT_W-1:0]         divisor;
    logic [SAMPLE_BITS-1:0]   mag;
    logic [2*SAMPLE_BITS-1:0] sq_full;
    logic [SQ_W-1:0]          ram_rdata;
    logic [SQ_W-1:0]          old_sq;
    logic [SUM_W-1:0]         sum_upd;
    logic [CNT_W:0]           seen_inc;
    logic [CNT_W-1:0]         run_len;
    logic [CNT_W:0]           trial;
    logic                     trial_ge;
    logic [CNT_W-1:0]         rem_next;
    logic [QX_W-1:0]          quot_x;
    logic                     out_free;

    // clamp to the supported window
    always_comb begin
        if (32'(hw_reg) > 32'(MAX_HALF_WINDOW)) begin
            win = CNT_W'(MAX_HALF_WINDOW);
        end else begin
            win = CNT_W'(hw_reg);
        end
    end

    assign span    = CNT_W'({win, 1'b0});
    assign divisor = span + CNT_W'(1);

    assign mag     = s_sample[SAMPLE_BITS-1] ? (~s_sample + SAMPLE_BITS'(1)) : s_sample;
    assign sq_full = (2*SAMPLE_BITS)'(mag) * (2*SAMPLE_BITS)'(mag);

    wste_ram #(
        .WIDTH (SQ_W),
        .DEPTH (RAM_D)
    ) u_hist (
        .aclk  (aclk),
        .we    (cmd.update),
        .waddr (wp_reg),
        .wdata (sq_reg),
        .raddr (wp_reg - span),
        .rdata (ram_rdata)
    );

    // square leaving the window; history not yet filled reads as zero
    always_comb begin
        if (span == '0) begin
            old_sq = sq_reg;
        end else if (samples_reg >= span) begin
            old_sq = ram_rdata;
        end else begin
            old_sq = '0;
        end
    end

    assign sum_upd  = sum_reg + SUM_W'(sq_reg) - SUM_W'(old_sq);
    assign seen_inc = {1'b0, samples_reg} + (CNT_W+1)'(1);
    assign run_len  = (seen_inc < {1'b0, win}) ? CNT_W'(seen_inc) : win;

    // restoring division, one quotient bit per step
    assign trial    = {rem_reg, qr_reg[SUM_W-1]};
    assign trial_ge = trial >= {1'b0, divisor};
    assign rem_next = trial_ge ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
    assign quot_x   = QX_W'(qr_reg);

    assign out_free = !m_valid_reg || m_ready;

    assign st.emit        = samples_reg >= win;
    assign st.need_div    = samples_reg >= span;
    assign st.last        = last_reg;
    assign st.run_pending = run_cnt_reg != '0;
    assign st.run_final   = run_cnt_reg == CNT_W'(1);
    assign st.div_done    = div_cnt_reg == DCNT_W'(SUM_W - 1);
    assign st.out_free    = out_free;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            sq_reg   <= sq_full[SQ_W-1:0];
            last_reg <= s_last;
        end
        if (cmd.update) begin
            qr_reg       <= sum_upd;
            rem_reg      <= '0;
            div_cnt_reg  <= '0;
            use_quot_reg <= samples_reg >= span;
        end else if (cmd.div_step) begin
            qr_reg      <= {qr_reg[SUM_W-2:0], trial_ge};
            rem_reg     <= rem_next;
            div_cnt_reg <= div_cnt_reg + DCNT_W'(1);
        end
        if (cmd.load_result) begin
            m_energy_reg <= use_quot_reg ? quot_x[ENERGY_W-1:0] : '0;
            m_last_reg   <= last_reg && (run_cnt_reg == '0);
        end else if (cmd.load_run) begin
            m_energy_reg <= '0;
            m_last_reg   <= run_cnt_reg == CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hw_reg      <= HALF_WINDOW_RESET;
            wp_reg      <= '0;
            sum_reg     <= '0;
            samples_reg <= '0;
            run_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hw_reg      <= cfg_wr_data;
                sum_reg     <= '0;
                samples_reg <= '0;
            end else if (cmd.update) begin
                wp_reg      <= wp_reg + CNT_W'(1);
                run_cnt_reg <= run_len;
                if (last_reg) begin
                    sum_reg     <= '0;
                    samples_reg <= '0;
                end else begin
                    sum_reg <= sum_upd;
                    if (samples_reg < CNT_W'(2 * MAX_HALF_WINDOW)) begin
                        samples_reg <= samples_reg + CNT_W'(1);
                    end
                end
            end else if (cmd.load_run) begin
                run_cnt_reg <= run_cnt_reg - CNT_W'(1);
            end

            if (cmd.load_result || cmd.load_run) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_energy      = m_energy_reg;
    assign m_last_result = m_last_reg;

endmodule

`default_nettype wire

>>> hw/rtl/windowed_short_time_energy_core.sv
// A full-window result passes the input register, the update step, the bit-serial divider
// and the emit step before m_valid; edge positions and trailing zeros skip the divider.
// A new sample is taken only once the previous one is through, the divider (one
// quotient bit a cycle) setting the pace; trailing zeros leave one a cycle while m_ready holds.
// Reset (aresetn, synchronous, active low): window sum, sample count and output valid
// clear, half_window returns to 8. The square history needs no clearing pass.
`default_nettype none

module windowed_short_time_energy_core
    import wste_pkg::*;
#(
    parameter int MAX_HALF_WINDOW = DEF_MAX_HALF_WINDOW,
    parameter int SAMPLE_BITS     = DEF_SAMPLE_BITS
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,

    // half_window register; a write restarts the array in progress
    input  wire logic                   cfg_wr_en,
    input  wire logic [WIN_W-1:0]       cfg_wr_data,

    // sample stream in
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic [SAMPLE_BITS-1:0] s_sample,
    input  wire logic                   s_last,

    // energy stream out
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [ENERGY_W-1:0]         m_energy,
    output logic                        m_last_result
);

    // Operation per sample transfer:
    //   accept  : square the sample, read the square that leaves the window
    //             from the ring buffer (address = write pointer - 2*win)
    //   update  : running sum += new square - departing square, store the new square
    //   divide  : sum / (2*win+1), restoring, one bit a cycle
    //   emit    : result into the output register, then the trailing zero run
    //             if this transfer closed the array.
    // Positions before the window fills give zero without dividing. The sample
    // count doubles as fill count for the history, so stale entries read as zero.
    // The output register lets a new sample transfer while a result still waits.

    wste_cmd_t    cmd;
    wste_status_t st;

    wste_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    wste_datapath #(
        .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
        .SAMPLE_BITS     (SAMPLE_BITS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_sample      (s_sample),
        .s_last        (s_last),
        .cmd           (cmd),
        .st            (st),
        .m_ready       (m_ready),
        .m_valid       (m_valid),
        .m_energy      (m_energy),
        .m_last_result (m_last_result)
    );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
// Testbench for windowed_short_time_energy_core: directed table plus random sample streams.
`timescale 1ns / 100ps

module tb_top;
    import wste_pkg::*;

    // ------------------------------------------------------------------
    // Run constants
    // ------------------------------------------------------------------
    localparam int SAMPLE_W     = DEF_SAMPLE_BITS;
    localparam int HIST_DEPTH   = 2 * DEF_MAX_HALF_WINDOW + 2;
    localparam int SEEN_CAP     = 2 * DEF_MAX_HALF_WINDOW;
    localparam int N_RANDOM     = 300;     // random sample transfers, roughly
    localparam int SETTLE       = 80;      // settle stretch, longer than a full-window sample's path
    localparam int LONG_HOLD    = 400;     // receiver back-pressure stretch
    localparam int CYCLE_LIMIT  = 500_000;

    typedef enum logic {ROW_SAMPLE, ROW_WINDOW} row_kind_t;

    // One directed step: either a sample transfer or a half_window write.
    // Where typed is set, the expected results are n_typed values, the first
    // carrying e_typed and the rest zero, the array flag on the final one.
    typedef struct packed {
        row_kind_t        kind;
        logic [15:0]      value;
        logic             last;
        logic             typed;
        logic [5:0]       n_typed;
        logic [30:0]      e_typed;
    } plan_row_t;

    typedef struct {
        logic [ENERGY_W-1:0] energy;
        logic                last;
    } energy_rec_t;

    localparam plan_row_t PLAN [26] = '{
        // reset window (8): a lone sample is a short array, one zero closes it
        '{ROW_SAMPLE, 16'h0000, 1'b1, 1'b1, 6'd1, 31'd0},
        // window 1, full-scale negative: 2 * 2^30 / 3
        '{ROW_WINDOW, 16'd1,    1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b0, 1'b1, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b0, 1'b1, 6'd1, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, 6'd2, 31'd715827882},
        // full-scale positive: 2 * 32767^2 / 3
        '{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b1, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b1, 6'd1, 31'd0},
        '{ROW_SAMPLE, 16'h7FFF, 1'b1, 1'b1, 6'd2, 31'd715784192},
        // empty window: one zero per sample, no trailing run
        '{ROW_WINDOW, 16'd0,    1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h0005, 1'b0, 1'b1, 6'd1, 31'd0},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, 1'b1, 6'd1, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, 6'd1, 31'd0},
        // widest window, short array: both results are the trailing run
        '{ROW_WINDOW, 16'd31,   1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h0007, 1'b0, 1'b1, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b1, 1'b1, 6'd2, 31'd0},
        // array left open, then a window write restarts it
        '{ROW_SAMPLE, 16'h0001, 1'b0, 1'b1, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h0002, 1'b0, 1'b1, 6'd0, 31'd0},
        '{ROW_WINDOW, 16'd2,    1'b0, 1'b0, 6'd0, 31'd0},
        // mixed signs and extremes, checked by the model
        '{ROW_SAMPLE, 16'h0064, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'hFF38, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h012C, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'hFE70, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h01F4, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h7FFF, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h8000, 1'b0, 1'b0, 6'd0, 31'd0},
        '{ROW_SAMPLE, 16'h0001, 1'b1, 1'b0, 6'd0, 31'd0}
    };

    // ------------------------------------------------------------------
    // DUT signals: every input known from time zero
    // ------------------------------------------------------------------
    logic                 aclk;
    logic                 aresetn       = 1'b0;
    logic                 cfg_wr_en     = 1'b0;
    logic [WIN_W-1:0]     cfg_wr_data   = '0;
    logic                 s_valid       = 1'b0;
    logic                 s_ready;
    logic [SAMPLE_W-1:0]  s_sample      = '0;
    logic                 s_last        = 1'b0;
    logic                 m_valid;
    logic                 m_ready       = 1'b0;
    logic [ENERGY_W-1:0]  m_energy;
    logic                 m_last_result;

    windowed_short_time_energy_core dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_sample      (s_sample),
        .s_last        (s_last),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_energy      (m_energy),
        .m_last_result (m_last_result)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------
    // Energy model: own copy of the square history, window sum, count and
    // half window. Advanced once per accepted sample transfer.
    // ------------------------------------------------------------------
    logic [30:0]       sq_hist [HIST_DEPTH];
    logic [35:0]       win_sum;
    int unsigned       seen_cnt;
    logic [WIN_W-1:0]  cur_half = HALF_WINDOW_RESET;

    energy_rec_t       energy_expect [$];   // results owed by the DUT, oldest first
    int                err_count    = 0;
    int                results_seen = 0;
    int                cycle_count  = 0;
    int                burst_left   = 0;
    bit                hold_req     = 1'b0;

    function automatic void clear_history();
        foreach (sq_hist[k]) sq_hist[k] = '0;
        win_sum  = '0;
        seen_cnt = 0;
    endfunction

    function automatic logic [30:0] square_of_sample(input logic [15:0] smp);
        logic [15:0] mag;
        // two's complement magnitude; 0x8000 stays 0x8000 = 32768 unsigned
        mag = smp[15] ? (~smp + 16'd1) : smp;
        return 31'(32'(mag) * 32'(mag));
    endfunction

    function automatic void predict_energy(input logic [15:0] smp, input logic lst,
                                           output energy_rec_t res[$]);
        int unsigned span;
        int unsigned pos;
        int unsigned run;
        int          k;
        logic [35:0] quo;
        res  = {};
        span = 2 * int'(cur_half);
        pos  = seen_cnt;

        for (k = HIST_DEPTH - 1; k > 0; k--) sq_hist[k] = sq_hist[k-1];
        sq_hist[0] = square_of_sample(smp);
        // entry span is the square that just left the window
        win_sum = win_sum + 36'(sq_hist[0]) - 36'(sq_hist[span]);

        if (pos >= int'(cur_half)) begin
            quo = '0;
            if (pos >= span) quo = win_sum / 36'(span + 1);
            res.push_back('{quo[ENERGY_W-1:0], 1'b0});
        end

        if (lst) begin
            // trailing zeros: the positions the window never reached
            run = (pos + 1 < int'(cur_half)) ? pos + 1 : int'(cur_half);
            for (k = 0; k < int'(run); k++) res.push_back('{'0, 1'b0});
            res[res.size()-1].last = 1'b1;
            clear_history();
        end else if (seen_cnt < SEEN_CAP) begin
            seen_cnt++;
        end
    endfunction

    initial clear_history();

    // ------------------------------------------------------------------
    // Reporting and result checking
    // ------------------------------------------------------------------
    task automatic report_mismatch(input string msg);
        if (err_count < 100) $display("%0t ns: result %0d: %s", $time, results_seen, msg);
        err_count++;
    endtask

    // Result transfers are sampled at the rising edge and popped in order.
    always @(posedge aclk) begin : energy_check
        energy_rec_t want;
        if (aresetn && m_valid && m_ready) begin
            if (energy_expect.size() == 0) begin
                report_mismatch($sformatf("unexpected transfer, energy %0d last %0b",
                                          m_energy, m_last_result));
            end else begin
                want = energy_expect.pop_front();
                if (m_energy !== want.energy)
                    report_mismatch($sformatf("energy %0d, expected %0d",
                                              m_energy, want.energy));
                if (m_last_result !== want.last)
                    report_mismatch($sformatf("last_result %0b, expected %0b",
                                              m_last_result, want.last));
            end
            results_seen++;
        end
    end

    // Watchdog: a hang or a lost result ends the run here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: m_ready changes at the falling edge. Modes last a random
    // stretch each: always ready, coin toss, mostly stalled, fixed pattern.
    // On request it holds m_ready low for the LONG_HOLD stretch so the core backs up
    // and has to drop s_ready.
    // ------------------------------------------------------------------
    initial begin : result_sink
        int mode;
        int mode_left;
        int tick;
        mode      = 0;
        mode_left = 0;
        tick      = 0;
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                m_ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
                hold_req = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(64, 256);
            end
            mode_left--;
            tick++;
            case (mode)
                0: m_ready <= 1'b1;
                1: m_ready <= 1'($urandom_range(0, 1));
                2: m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= ((tick % 8) >= 3);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One sample transfer. Bursts of random length, random gaps between them
    // (zero gaps too, so some stretches run back to back). Payload changes
    // only at the falling edge; valid holds until the rising edge that takes
    // the transfer, where the model is advanced.
    task automatic send_sample(input logic [15:0] smp, input logic lst,
                               input logic typed, input logic [5:0] n_typed,
                               input logic [30:0] e_typed);
        int           gap;
        int           j;
        energy_rec_t  res [$];
        @(negedge aclk);
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 45);
            burst_left = $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid  <= 1'b1;
        s_sample <= smp;
        s_last   <= lst;
        do @(posedge aclk); while (s_ready !== 1'b1);

        predict_energy(smp, lst, res);
        if (typed) begin
            // expectation read straight off the behaviour, model only advances
            res = {};
            for (j = 0; j < int'(n_typed); j++)
                res.push_back('{(j == 0) ? e_typed : 31'd0,
                                lst && (j == int'(n_typed) - 1)});
        end
        foreach (res[j]) energy_expect.push_back(res[j]);
    endtask

    // Sender pauses: valid drops at the next falling edge, then wait until
    // every owed result has been taken.
    task automatic wait_results_done();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (energy_expect.size() != 0) @(posedge aclk);
    endtask

    // half_window write, only with the core idle. A sample that produces no
    // result may still be in its update step, hence the settle stretch.
    task automatic set_half_window(input logic [WIN_W-1:0] w);
        wait_results_done();
        repeat (SETTLE) @(posedge aclk);
        @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= w;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        cur_half = w;
        clear_history();
    endtask

    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'hFFFF;
            3: return 16'h0000;
            default: return 16'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin : stimulus
        int          r;
        int          random_sent;
        int          phase_no;
        int          w;
        int          n_arr;
        int          a;
        int          k;
        int          len;
        int          pick;
        bit          open_end;
        bit          full_scale;
        logic        lst;
        logic [15:0] fs_val;

        random_sent = 0;
        phase_no    = 0;

        // reset held low from time zero, released on a falling edge
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        for (r = 0; r < 26; r++) begin
            if (PLAN[r].kind == ROW_WINDOW)
                set_half_window(PLAN[r].value[WIN_W-1:0]);
            else
                send_sample(PLAN[r].value, PLAN[r].last, PLAN[r].typed,
                            PLAN[r].n_typed, PLAN[r].e_typed);
        end

        // random phases: one window setting each, then a few arrays. The
        // first three phases pin window 1 (with the long receiver hold),
        // 31 (with a full-scale array long enough to fill it) and 0.
        while (random_sent < N_RANDOM) begin
            if (phase_no == 0)      w = 1;
            else if (phase_no == 1) w = 31;
            else if (phase_no == 2) w = 0;
            else if ($urandom_range(0, 4) == 0) w = $urandom_range(0, 1) ? 31 : 0;
            else w = $urandom_range(1, 20);
            set_half_window(WIN_W'(w));
            if (phase_no == 0) hold_req = 1'b1;

            n_arr    = $urandom_range(1, 3);
            open_end = ($urandom_range(0, 5) == 0);
            for (a = 0; a < n_arr; a++) begin
                if (w == 0) begin
                    len = $urandom_range(1, 6);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 7)      len = $urandom_range(2 * w + 1, 2 * w + 10);
                    else if (pick < 9) len = $urandom_range(1, w);
                    else               len = $urandom_range(w + 1, 2 * w);
                end
                full_scale = ($urandom_range(0, 5) == 0);
                if (phase_no == 1 && a == 0) begin
                    full_scale = 1'b1;
                    len        = 70;
                end
                fs_val = $urandom_range(0, 1) ? 16'h8000 : 16'h7FFF;

                for (k = 0; k < len; k++) begin
                    // an open final array is restarted by the next window write
                    lst = (k == len - 1) && !(open_end && a == n_arr - 1);
                    send_sample(full_scale ? fs_val : pick_sample(), lst,
                                1'b0, 6'd0, 31'd0);
                    random_sent++;
                    if ($urandom_range(0, 29) == 0) wait_results_done();
                end
            end
            phase_no++;
        end

        // drain, then give the core time to show any stray transfer
        wait_results_done();
        repeat (SETTLE) @(posedge aclk);

        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
